### hdl/glcd_dwr_pkg.sv
// ----------------------------------------------------------------------------
// glcd_dwr_pkg: shared types and constants of the dirty-word refresh unit
// Field widths, LCD command bytes, the byte-sequencer step type and the
// descriptor of one pending update run.
// ----------------------------------------------------------------------------
package glcd_dwr_pkg;

    // Fixed field widths of the request and result channels.
    localparam int ROW_W  = 6;
    localparam int COL_W  = 3;
    localparam int WORD_W = 16;
    localparam int BYTE_W = 8;

    // LCD controller command bytes.
    localparam logic [BYTE_W-1:0] CMD_EXT_MODE   = 8'h36;
    localparam logic [BYTE_W-1:0] CMD_BASIC_MODE = 8'h30;
    localparam logic [BYTE_W-1:0] CMD_ADDR       = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_ADDR_LOWER = 8'h88;

    // Position within the six-byte update sequence.
    typedef enum logic [2:0] {
        STEP_EXT,
        STEP_ROW,
        STEP_COL,
        STEP_HIGH,
        STEP_LOW,
        STEP_BASIC
    } step_t;

    // Everything the byte sequencer needs to emit one update run.
    typedef struct packed {
        logic [BYTE_W-1:0] vaddr_cmd;
        logic [BYTE_W-1:0] haddr_cmd;
        logic [WORD_W-1:0] word;
    } run_t;

endpackage

### hdl/graphic_lcd_dirty_word_refresh_unit.sv
// ----------------------------------------------------------------------------
// graphic_lcd_dirty_word_refresh_unit: partial GDRAM update for a 128x64 LCD
// Compares each incoming 16-pixel word with the copy last sent for its place
// and, when it differs, stores it and emits the six-byte LCD bus sequence.
// ----------------------------------------------------------------------------
// After reset the unit zeroes all 2*HALF_ROWS*WORDS_PER_ROW entries (512 by
// default) of its shadow memory, with in_stall high. It then takes one
// request per cycle while in_stall is low: a word equal to the stored copy,
// or one whose row or column lies outside the frame, produces nothing. A
// changed word holds the byte sequencer for six result requests; a later one
// waits in the compare stage until it is free. Bytes leave one per cycle
// while out_stall is low, each from the registered sequencer state.
module graphic_lcd_dirty_word_refresh_unit #(
    parameter int HALF_ROWS     = 32,
    parameter int WORDS_PER_ROW = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [glcd_dwr_pkg::ROW_W-1:0]  pixel_row,
    input  logic [glcd_dwr_pkg::COL_W-1:0]  word_column,
    input  logic [glcd_dwr_pkg::WORD_W-1:0] pixel_word,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [glcd_dwr_pkg::BYTE_W-1:0] bus_byte,
    output logic                            is_data,
    output logic                            last_of_run
);
    import glcd_dwr_pkg::*;

    localparam int TOTAL_ROWS = 2 * HALF_ROWS;
    localparam int DEPTH      = TOTAL_ROWS * WORDS_PER_ROW;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              in_fire;
    logic              in_ok;
    logic              in_upper;
    logic [ADDR_W-1:0] in_idx;
    logic [ROW_W-1:0]  in_row_off;
    run_t              in_run;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_ok_reg;
    logic [ADDR_W-1:0] s1_idx_reg;
    run_t              s1_run_reg;
    logic [WORD_W-1:0] s1_old;
    logic              s1_changed;
    logic              s1_go;

    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [WORD_W-1:0] fwd_data_reg;

    logic [WORD_W-1:0] rd_data;
    logic              wr_en;
    logic              clearing;
    logic              seq_free;

    // Request decode: range check, store index and the two address commands.
    assign in_fire    = in_valid && !in_stall;
    assign in_ok      = (32'(pixel_row) < 32'(TOTAL_ROWS)) &&
                        (32'(word_column) < 32'(WORDS_PER_ROW));
    assign in_upper   = (32'(pixel_row) < 32'(HALF_ROWS));
    assign in_idx     = ADDR_W'(32'(pixel_row) * 32'(WORDS_PER_ROW) + 32'(word_column));
    assign in_row_off = in_upper ? pixel_row : ROW_W'(32'(pixel_row) - 32'(HALF_ROWS));

    assign in_run.vaddr_cmd = CMD_ADDR + BYTE_W'(in_row_off);
    assign in_run.haddr_cmd = (in_upper ? CMD_ADDR : CMD_ADDR_LOWER) + BYTE_W'(word_column);
    assign in_run.word      = pixel_word;

    // Shadow memory of the words on the display.
    glcd_dwr_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (in_fire),
        .rd_addr  (in_idx),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (s1_idx_reg),
        .wr_data  (s1_run_reg.word),
        .clearing (clearing)
    );

    // Compare stage; the latest write is forwarded over a stale read.
    assign s1_old     = (fwd_valid_reg && (fwd_addr_reg == s1_idx_reg)) ?
                        fwd_data_reg : rd_data;
    assign s1_changed = s1_valid_reg && s1_ok_reg && (s1_old != s1_run_reg.word);
    assign s1_go      = s1_valid_reg && (!s1_changed || seq_free);
    assign wr_en      = s1_go && s1_changed;
    assign in_stall   = clearing || (s1_valid_reg && !s1_go);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // Stage payload and last-write copy need no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ok_reg  <= in_ok;
            s1_idx_reg <= in_idx;
            s1_run_reg <= in_run;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_idx_reg;
            fwd_data_reg <= s1_run_reg.word;
        end
    end

    // Output byte sequencer.
    glcd_dwr_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (wr_en),
        .run         (s1_run_reg),
        .free        (seq_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bus_byte    (bus_byte),
        .is_data     (is_data),
        .last_of_run (last_of_run)
    );

    // A changed word only leaves the compare stage into a free sequencer.
    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> seq_free)
        else $error("update run loaded while sequencer busy");

    // No request reaches the compare stage during the clearing pass.
    a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!s1_valid_reg && in_stall))
        else $error("request in flight during clearing pass");

    // A held compare stage keeps the same entry.
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(s1_idx_reg)))
        else $error("compare stage lost its request while held");

    // The last byte of a run is always the basic-mode command.
    a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_run) |-> ((bus_byte == CMD_BASIC_MODE) && !is_data))
        else $error("run ended with the wrong byte");

endmodule

### hdl/glcd_dwr_store.sv
// ----------------------------------------------------------------------------
// glcd_dwr_store: shadow copy of the words last sent to the display
// Simple dual-port synchronous memory with a registered read, plus the
// clearing pass that zeroes every entry after reset.
// ----------------------------------------------------------------------------
module glcd_dwr_store #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [ADDR_W-1:0]               rd_addr,
    output logic [glcd_dwr_pkg::WORD_W-1:0] rd_data,
    input  logic                            wr_en,
    input  logic [ADDR_W-1:0]               wr_addr,
    input  logic [glcd_dwr_pkg::WORD_W-1:0] wr_data,
    output logic                            clearing
);
    import glcd_dwr_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              clearing_reg;
    logic              clearing_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    // The clearing pass walks every entry once, one per cycle.
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // The write port is shared between the clearing pass and updates.
    assign mem_we    = clearing_reg || wr_en;
    assign mem_waddr = clearing_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata = clearing_reg ? '0 : wr_data;

    // Memory array; a read in the same cycle as a write returns the old word.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

### hdl/glcd_dwr_seq.sv
// ----------------------------------------------------------------------------
// glcd_dwr_seq: LCD bus byte sequencer
// Holds one update run and plays it out as six bus bytes, one per accepted
// result request.
// ----------------------------------------------------------------------------
module glcd_dwr_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  glcd_dwr_pkg::run_t              run,
    output logic                            free,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [glcd_dwr_pkg::BYTE_W-1:0] bus_byte,
    output logic                            is_data,
    output logic                            last_of_run
);
    import glcd_dwr_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  valid_reg;
    logic  valid_next;
    run_t  run_reg;
    logic  out_fire;
    logic  at_last;

    assign out_fire = valid_reg && !out_stall;
    assign at_last  = (step_reg == STEP_BASIC);

    // A new run may load while the final byte of the current one leaves.
    assign free = !valid_reg || (out_fire && at_last);

    // Next step of the sequence.
    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (out_fire)
        begin
            unique case (step_reg)
                STEP_EXT:   step_next = STEP_ROW;
                STEP_ROW:   step_next = STEP_COL;
                STEP_COL:   step_next = STEP_HIGH;
                STEP_HIGH:  step_next = STEP_LOW;
                STEP_LOW:   step_next = STEP_BASIC;
                STEP_BASIC:
                begin
                    step_next  = STEP_EXT;
                    valid_next = 1'b0;
                end
                default:    step_next = STEP_EXT;
            endcase
        end
        if (load)
        begin
            step_next  = STEP_EXT;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_EXT;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Run payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            run_reg <= run;
        end
    end

    // Byte and register-select for the current step.
    always_comb
    begin
        bus_byte    = CMD_BASIC_MODE;
        is_data     = 1'b0;
        last_of_run = 1'b0;
        unique case (step_reg)
            STEP_EXT:   bus_byte = CMD_EXT_MODE;
            STEP_ROW:   bus_byte = run_reg.vaddr_cmd;
            STEP_COL:   bus_byte = run_reg.haddr_cmd;
            STEP_HIGH:
            begin
                bus_byte = run_reg.word[WORD_W-1 -: BYTE_W];
                is_data  = 1'b1;
            end
            STEP_LOW:
            begin
                bus_byte = run_reg.word[BYTE_W-1:0];
                is_data  = 1'b1;
            end
            STEP_BASIC:
            begin
                bus_byte    = CMD_BASIC_MODE;
                last_of_run = 1'b1;
            end
            default:    bus_byte = CMD_BASIC_MODE;
        endcase
    end

    assign out_valid = valid_reg;

endmodule

### tb/graphic_lcd_dirty_word_refresh_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graphic_lcd_dirty_word_refresh_unit_checker: bus write predictor and scoreboard
// Watches the pixel-word request channel and the LCD bus write channel. It
// keeps its own copy of the shown frame, turns every accepted request that
// changes a word into the six expected bus writes, and compares each accepted
// bus write with the oldest expected one.
// ----------------------------------------------------------------------------
module graphic_lcd_dirty_word_refresh_unit_checker #(
    parameter int HALF_ROWS     = 32,
    parameter int WORDS_PER_ROW = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [glcd_dwr_pkg::ROW_W-1:0]  pixel_row,
    input  logic [glcd_dwr_pkg::COL_W-1:0]  word_column,
    input  logic [glcd_dwr_pkg::WORD_W-1:0] pixel_word,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [glcd_dwr_pkg::BYTE_W-1:0] bus_byte,
    input  logic                            is_data,
    input  logic                            last_of_run,
    output int                              error_count,
    output int                              writes_pending,
    output int                              writes_checked
);
    import glcd_dwr_pkg::*;

    localparam int FRAME_WORDS = 2 * HALF_ROWS * WORDS_PER_ROW;

    // One write on the LCD bus.
    typedef struct packed {
        logic [BYTE_W-1:0] bus_byte;
        logic              is_data;
        logic              last_of_run;
    } lcd_write_t;

    logic [WORD_W-1:0] shown_copy [0:FRAME_WORDS-1];
    lcd_write_t        expected_writes [$];

    // Appends one bus write to the list of expected writes.
    function automatic void queue_write(input logic [BYTE_W-1:0] b, input logic d,
                                        input logic l);
        lcd_write_t w;
        w.bus_byte    = b;
        w.is_data     = d;
        w.last_of_run = l;
        expected_writes.push_back(w);
    endfunction

    // Works out the bus writes that one pixel-word request causes.
    function automatic void predict_refresh(input logic [ROW_W-1:0] row,
                                            input logic [COL_W-1:0] col,
                                            input logic [WORD_W-1:0] word);
        int unsigned       slot;
        logic [BYTE_W-1:0] row_cmd;
        logic [BYTE_W-1:0] col_cmd;
        if (int'(row) >= 2 * HALF_ROWS || int'(col) >= WORDS_PER_ROW)
            return;
        slot = int'(row) * WORDS_PER_ROW + int'(col);
        if (shown_copy[slot] == word)
            return;
        shown_copy[slot] = word;
        // The lower half of the panel reuses the upper row addresses.
        if (int'(row) < HALF_ROWS)
        begin
            row_cmd = BYTE_W'(int'(CMD_ADDR) + int'(row));
            col_cmd = BYTE_W'(int'(CMD_ADDR) + int'(col));
        end
        else
        begin
            row_cmd = BYTE_W'(int'(CMD_ADDR) + int'(row) - HALF_ROWS);
            col_cmd = BYTE_W'(int'(CMD_ADDR_LOWER) + int'(col));
        end
        queue_write(CMD_EXT_MODE, 1'b0, 1'b0);
        queue_write(row_cmd, 1'b0, 1'b0);
        queue_write(col_cmd, 1'b0, 1'b0);
        queue_write(word[15:8], 1'b1, 1'b0);
        queue_write(word[7:0], 1'b1, 1'b0);
        queue_write(CMD_BASIC_MODE, 1'b0, 1'b1);
    endfunction

    // Prediction on accepted requests, comparison on accepted bus writes.
    always @(posedge clk or negedge rst_n)
    begin
        lcd_write_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_WORDS; i++)
                shown_copy[i] = '0;
            expected_writes.delete();
            error_count    = 0;
            writes_checked = 0;
            writes_pending = 0;
        end
        else
        begin
            if (in_valid === 1'b1 && in_stall === 1'b0)
                predict_refresh(pixel_row, word_column, pixel_word);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                writes_checked++;
                if (expected_writes.size() == 0)
                begin
                    $error("unexpected bus write: bus_byte=%h is_data=%b last_of_run=%b",
                           bus_byte, is_data, last_of_run);
                    error_count++;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (bus_byte !== want.bus_byte)
                    begin
                        $error("bus_byte: expected %h, actual %h", want.bus_byte, bus_byte);
                        error_count++;
                    end
                    if (is_data !== want.is_data)
                    begin
                        $error("is_data: expected %b, actual %b", want.is_data, is_data);
                        error_count++;
                    end
                    if (last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %b, actual %b",
                               want.last_of_run, last_of_run);
                        error_count++;
                    end
                end
            end
            writes_pending = expected_writes.size();
        end
    end

endmodule

### tb/graphic_lcd_dirty_word_refresh_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graphic_lcd_dirty_word_refresh_unit_tb: testbench of the dirty-word refresh unit
// Sends directed and random pixel-word requests over the whole panel, with
// random idling on both channels, a calm stretch and one long output
// hold-off. A separate checker predicts and compares the LCD bus writes.
// ----------------------------------------------------------------------------
module graphic_lcd_dirty_word_refresh_unit_tb;
    import glcd_dwr_pkg::*;

    localparam int HALF_ROWS      = 32;
    localparam int WORDS_PER_ROW  = 8;
    localparam int FRAME_WORDS    = 2 * HALF_ROWS * WORDS_PER_ROW;
    localparam int RANDOM_ITEMS   = 300;
    localparam int CALM_FIRST     = 100;
    localparam int CALM_LAST      = 170;
    localparam int HOLD_AT        = 240;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 4000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [ROW_W-1:0]  pixel_row;
    logic [COL_W-1:0]  word_column;
    logic [WORD_W-1:0] pixel_word;
    logic              out_valid;
    logic              out_stall;
    logic [BYTE_W-1:0] bus_byte;
    logic              is_data;
    logic              last_of_run;

    int error_count;
    int writes_pending;
    int writes_checked;
    int requests_sent;
    int quiet_cycles;
    bit calm;
    bit hold_done;

    // Last word offered for each place, used to shape repeats and bit flips.
    logic [WORD_W-1:0] offered_word [0:FRAME_WORDS-1];

    graphic_lcd_dirty_word_refresh_unit #(
        .HALF_ROWS     (HALF_ROWS),
        .WORDS_PER_ROW (WORDS_PER_ROW)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_row   (pixel_row),
        .word_column (word_column),
        .pixel_word  (pixel_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bus_byte    (bus_byte),
        .is_data     (is_data),
        .last_of_run (last_of_run)
    );

    graphic_lcd_dirty_word_refresh_unit_checker #(
        .HALF_ROWS     (HALF_ROWS),
        .WORDS_PER_ROW (WORDS_PER_ROW)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pixel_row      (pixel_row),
        .word_column    (word_column),
        .pixel_word     (pixel_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bus_byte       (bus_byte),
        .is_data        (is_data),
        .last_of_run    (last_of_run),
        .error_count    (error_count),
        .writes_pending (writes_pending),
        .writes_checked (writes_checked)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offers one request, after a random idle gap unless calm, and waits until it is taken.
    task automatic offer(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                         input logic [WORD_W-1:0] word);
        int gap;
        gap = 0;
        if (!calm)
            while (gap < 12 && $urandom_range(99) < 35)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_row   <= row;
        word_column <= col;
        pixel_word  <= word;
        offered_word[int'(row) * WORDS_PER_ROW + int'(col)] = word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    // Request stimulus and verdict.
    initial
    begin
        int                n;
        int                pick;
        int                slot;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [WORD_W-1:0] word;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        pixel_row     <= '0;
        word_column   <= '0;
        pixel_word    <= '0;
        requests_sent = 0;
        calm          = 1'b0;
        for (int i = 0; i < FRAME_WORDS; i++)
            offered_word[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: panel corners, both halves, repeats and zero words.
        offer(6'd0, 3'd0, 16'h0000);
        offer(6'd0, 3'd0, 16'hFFFF);
        offer(6'd0, 3'd0, 16'hFFFF);
        offer(6'd0, 3'd0, 16'h0000);
        offer(6'd31, 3'd7, 16'h8000);
        offer(6'd32, 3'd0, 16'h0001);
        offer(6'd63, 3'd7, 16'hFFFF);
        offer(6'd63, 3'd7, 16'h0000);
        offer(6'd32, 3'd7, 16'hA5A5);
        offer(6'd31, 3'd0, 16'h5A5A);
        offer(6'd16, 3'd3, 16'h1234);
        offer(6'd48, 3'd4, 16'hFEDC);
        offer(6'd48, 3'd4, 16'hFEDC);
        offer(6'd47, 3'd5, 16'h0000);
        offer(6'd1, 3'd1, 16'h00FF);
        offer(6'd1, 3'd1, 16'hFF00);
        offer(6'd63, 3'd0, 16'h7FFF);
        offer(6'd0, 3'd7, 16'hFFFE);

        // Random part: mostly changed words, with repeats and single-bit changes.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= CALM_FIRST && n < CALM_LAST);
            pick = $urandom_range(99);
            row  = ROW_W'($urandom_range(2 * HALF_ROWS - 1));
            col  = COL_W'($urandom_range(WORDS_PER_ROW - 1));
            if (pick < 20)
            begin
                case ($urandom_range(3))
                    0: row = 6'd0;
                    1: row = 6'd31;
                    2: row = 6'd32;
                    default: row = 6'd63;
                endcase
            end
            slot = int'(row) * WORDS_PER_ROW + int'(col);
            word = WORD_W'($urandom_range(16'hFFFF));
            if (pick >= 20 && pick < 35)
                word = offered_word[slot];
            else if (pick >= 35 && pick < 43)
                word = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            else if (pick >= 43 && pick < 55)
                word = offered_word[slot] ^ (16'h0001 << $urandom_range(15));
            offer(row, col, word);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // Let every expected bus write arrive, then allow for late extras.
        while (writes_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixel-word requests over both panel halves; %0d bus writes checked.",
                 requests_sent, writes_checked);
        $display("The run included a calm stretch and a long hold-off on the bus side.");
        if (writes_pending != 0)
            $error("%0d expected bus writes never arrived", writes_pending);
        if (error_count == 0 && writes_pending == 0)
            $display("graphic_lcd_dirty_word_refresh_unit_tb passed");
        else
            $display("graphic_lcd_dirty_word_refresh_unit_tb failed");
        $finish;
    end

    // Bus side: random stall, a calm stretch and one long hold-off.
    initial
    begin
        out_stall <= 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && requests_sent >= HOLD_AT)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
                out_stall <= (!calm && $urandom_range(99) < 35);
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("graphic_lcd_dirty_word_refresh_unit_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
